FILE: rtl/core/vam_pkg.sv
// vam_pkg: item types and fixed widths for the vector align rotation matrix core
// no dependencies; imported by the core, its checker and the testbench
`default_nettype none

package vam_pkg;

    // fixed field and datapath widths
    localparam int FIELD_W = 16;
    localparam int AXIS_W  = 33;
    localparam int MAG_W   = 32;
    localparam int LEN2_W  = 64;
    localparam int ROOT_W  = LEN2_W / 2;

    // slots of the outer-product terms
    localparam int KK_XX = 0;
    localparam int KK_YY = 1;
    localparam int KK_ZZ = 2;
    localparam int KK_XY = 3;
    localparam int KK_XZ = 4;
    localparam int KK_YZ = 5;
    localparam int KK_N  = 6;

    // slots of per-axis values
    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;
    localparam int AX_N = 3;

    typedef struct packed {
        logic signed [FIELD_W-1:0] spatial_x;
        logic signed [FIELD_W-1:0] spatial_y;
        logic signed [FIELD_W-1:0] spatial_z;
        logic signed [FIELD_W-1:0] material_x;
        logic signed [FIELD_W-1:0] material_y;
        logic signed [FIELD_W-1:0] material_z;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] r00;
        logic signed [FIELD_W-1:0] r01;
        logic signed [FIELD_W-1:0] r02;
        logic signed [FIELD_W-1:0] r10;
        logic signed [FIELD_W-1:0] r11;
        logic signed [FIELD_W-1:0] r12;
        logic signed [FIELD_W-1:0] r20;
        logic signed [FIELD_W-1:0] r21;
        logic signed [FIELD_W-1:0] r22;
        logic                      antiparallel_flag;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/core/vam_isqrt.sv
// vam_isqrt: pipelined floor square root, one root bit per stage, with a side payload
// no package dependencies
`default_nettype none

module vam_isqrt #(
    parameter int W  = 64,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [W-1:0]  i_arg,
    input  logic [PW-1:0] i_pass,
    output logic [W/2-1:0] o_root,
    output logic [PW-1:0] o_pass
);

    localparam int R   = W / 2;
    localparam int RMW = R + 2;

    logic [RMW-1:0] r_rem  [R];
    logic [R-1:0]   r_root [R];
    logic [W-1:0]   r_arg  [R];
    logic [PW-1:0]  r_pass [R];

    for (genvar k = 0; k < R; k++) begin : g_stg
        logic [RMW-1:0] p_rem;
        logic [R-1:0]   p_root;
        logic [W-1:0]   p_arg;
        logic [PW-1:0]  p_pass;
        logic [RMW-1:0] cat;
        logic [RMW-1:0] trial;
        logic [RMW-1:0] n_rem;
        logic [R-1:0]   n_root;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_arg  = i_arg;
            assign p_pass = i_pass;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_arg  = r_arg[k-1];
            assign p_pass = r_pass[k-1];
        end

        always_comb begin
            cat   = {p_rem[R-1:0], p_arg[W-1:W-2]};
            trial = {p_root, 2'b01};
            if (cat >= trial) begin
                n_rem  = cat - trial;
                n_root = {p_root[R-2:0], 1'b1};
            end else begin
                n_rem  = cat;
                n_root = {p_root[R-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_arg[k]  <= {p_arg[W-3:0], 2'b00};
                r_pass[k] <= p_pass;
            end
        end
    end

    assign o_root = r_root[R-1];
    assign o_pass = r_pass[R-1];

endmodule

`default_nettype wire

FILE: rtl/core/vam_div.sv
// vam_div: pipelined restoring divider, one quotient bit per stage, with a side payload
// no package dependencies; caller supplies a partial remainder below the divisor
`default_nettype none

module vam_div #(
    parameter int DW = 32,
    parameter int QW = 15,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_lo,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pass,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_pass
);

    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_lo   [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [PW-1:0] r_pass [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stg
        logic [DW-1:0] p_rem;
        logic [QW-1:0] p_lo;
        logic [QW-1:0] p_quo;
        logic [DW-1:0] p_den;
        logic [PW-1:0] p_pass;
        logic [DW:0]   cat;
        logic [DW:0]   diff;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign p_rem  = i_rem;
            assign p_lo   = i_lo;
            assign p_quo  = '0;
            assign p_den  = i_den;
            assign p_pass = i_pass;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_lo   = r_lo[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_den  = r_den[k-1];
            assign p_pass = r_pass[k-1];
        end

        always_comb begin
            cat  = {p_rem, p_lo[QW-1]};
            diff = cat - {1'b0, p_den};
            if (cat >= {1'b0, p_den}) begin
                n_rem = diff[DW-1:0];
                n_quo = {p_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = cat[DW-1:0];
                n_quo = {p_quo[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_lo[k]   <= {p_lo[QW-2:0], 1'b0};
                r_quo[k]  <= n_quo;
                r_den[k]  <= p_den;
                r_pass[k] <= p_pass;
            end
        end
    end

    assign o_quo  = r_quo[QW-1];
    assign o_pass = r_pass[QW-1];

endmodule

`default_nettype wire

FILE: rtl/core/vector_align_rotation_matrix_core.sv
// throughput: one item per cycle while the result is not held, fully pipelined; the depth is
// set by the 32-stage square root of the axis length followed by the FRAC_BITS+1 stage divide
// and sine root in parallel
// a stalled result freezes the whole pipeline; nothing is lost or repeated
// reset (synchronous, active low) clears the valid bits only; datapath is not reset
`default_nettype none

module vector_align_rotation_matrix_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  vam_pkg::t_in_item    i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output vam_pkg::t_out_item   o_item
);

    import vam_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int KW   = F + 2;              // signed unit values: k, c, s
    localparam int QW   = F + 1;              // quotient and sine root bits
    localparam int SQW  = 2 * F + 2;          // sine root argument
    localparam int NUMW = MAG_W + F + 1;      // rounded divide numerator
    localparam int PKW  = 2 * KW;             // product of two unit values
    localparam int TW   = 2 * KW + 1;         // (1-c) times a rounded product
    localparam int XW   = (2 * F + 5 > 36) ? 2 * F + 5 : 36;
    localparam int EW   = (F + 4 > FIELD_W) ? F + 4 : FIELD_W;
    localparam int LAT  = 3 + ROOT_W + QW + 4;

    localparam logic signed [KW-1:0] ONE_K  = {2'b01, {F{1'b0}}};
    localparam logic signed [KW-1:0] MONE_K = {2'b11, {F{1'b0}}};
    localparam logic signed [XW-1:0] ONE_X  = XW'(ONE_K);
    localparam logic signed [XW-1:0] MONE_X = XW'(MONE_K);
    localparam logic signed [EW-1:0] ONE_E  = EW'(ONE_K);
    localparam logic signed [EW-1:0] MONE_E = EW'(MONE_K);
    localparam logic signed [KW:0]   ONE_T  = (KW+1)'(ONE_K);
    localparam logic [SQW-1:0]       ONE_SQ = {2'b01, {(2*F){1'b0}}};
    localparam logic [XW-1:0]        HALF   = {{(XW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    // payload carried through the axis length root
    typedef struct packed {
        logic [AX_N-1:0][MAG_W-1:0] mag;
        logic [AX_N-1:0]            neg;
        logic signed [KW-1:0]       c;
        logic                       dneg;
        logic [SQW-1:0]             sarg;
    } t_lenp;

    // payload carried through the sine root
    typedef struct packed {
        logic signed [KW-1:0] c;
        logic                 zero;
        logic                 dneg;
    } t_sinp;

    // round to nearest at FRAC_BITS, halves away from zero
    function automatic logic signed [XW-1:0] rshr(input logic signed [XW-1:0] x);
        logic [XW-1:0] mag;
        logic [XW-1:0] m;
        mag = x[XW-1] ? ~x + 1'b1 : x;
        m   = (mag + HALF) >> F;
        return x[XW-1] ? $signed(~m + 1'b1) : $signed(m);
    endfunction

    // clamp to plus or minus one and keep the field bits
    function automatic logic [FIELD_W-1:0] sat16(input logic signed [EW-1:0] e);
        logic signed [EW-1:0] v;
        if (e > ONE_E) begin
            v = ONE_E;
        end else if (e < MONE_E) begin
            v = MONE_E;
        end else begin
            v = e;
        end
        return v[FIELD_W-1:0];
    endfunction

    // global advance: the pipeline moves unless the result is held
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // stage 1: cross and dot products
    logic signed [AXIS_W-1:0] n1_a [AX_N];
    logic signed [AXIS_W-1:0] n1_dot;
    logic signed [AXIS_W-1:0] r1_a [AX_N];
    logic signed [AXIS_W-1:0] r1_dot;

    always_comb begin
        n1_a[AX_X] = AXIS_W'(i_item.material_y) * AXIS_W'(i_item.spatial_z)
                   - AXIS_W'(i_item.material_z) * AXIS_W'(i_item.spatial_y);
        n1_a[AX_Y] = AXIS_W'(i_item.material_z) * AXIS_W'(i_item.spatial_x)
                   - AXIS_W'(i_item.material_x) * AXIS_W'(i_item.spatial_z);
        n1_a[AX_Z] = AXIS_W'(i_item.material_x) * AXIS_W'(i_item.spatial_y)
                   - AXIS_W'(i_item.material_y) * AXIS_W'(i_item.spatial_x);
        n1_dot     = AXIS_W'(i_item.material_x) * AXIS_W'(i_item.spatial_x)
                   + AXIS_W'(i_item.material_y) * AXIS_W'(i_item.spatial_y)
                   + AXIS_W'(i_item.material_z) * AXIS_W'(i_item.spatial_z);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a   <= n1_a;
            r1_dot <= n1_dot;
        end
    end

    // stage 2: axis magnitudes and squares, clamped cosine
    logic [AX_N-1:0][MAG_W-1:0] n2_mag;
    logic [AX_N-1:0]            n2_neg;
    logic [LEN2_W-1:0]          n2_sq [AX_N];
    logic signed [XW-1:0]       n2_cr;
    logic signed [KW-1:0]       n2_c;
    logic [AX_N-1:0][MAG_W-1:0] r2_mag;
    logic [AX_N-1:0]            r2_neg;
    logic [LEN2_W-1:0]          r2_sq [AX_N];
    logic signed [KW-1:0]       r2_c;
    logic                       r2_dneg;

    always_comb begin
        for (int j = 0; j < AX_N; j++) begin
            n2_neg[j] = r1_a[j][AXIS_W-1];
            n2_mag[j] = n2_neg[j] ? MAG_W'(-r1_a[j]) : MAG_W'(r1_a[j]);
            n2_sq[j]  = LEN2_W'(n2_mag[j]) * LEN2_W'(n2_mag[j]);
        end
        n2_cr = rshr(XW'(r1_dot));
        if (n2_cr > ONE_X) begin
            n2_c = ONE_K;
        end else if (n2_cr < MONE_X) begin
            n2_c = MONE_K;
        end else begin
            n2_c = n2_cr[KW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_mag  <= n2_mag;
            r2_neg  <= n2_neg;
            r2_sq   <= n2_sq;
            r2_c    <= n2_c;
            r2_dneg <= r1_dot[AXIS_W-1];
        end
    end

    // stage 3: squared axis length and squared cosine
    logic signed [PKW-1:0]      n3_ccp;
    logic [LEN2_W-1:0]          r3_len2;
    logic [SQW-1:0]             r3_cc;
    logic [AX_N-1:0][MAG_W-1:0] r3_mag;
    logic [AX_N-1:0]            r3_neg;
    logic signed [KW-1:0]       r3_c;
    logic                       r3_dneg;

    assign n3_ccp = r2_c * r2_c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_len2 <= r2_sq[AX_X] + r2_sq[AX_Y] + r2_sq[AX_Z];
            r3_cc   <= n3_ccp[SQW-1:0];
            r3_mag  <= r2_mag;
            r3_neg  <= r2_neg;
            r3_c    <= r2_c;
            r3_dneg <= r2_dneg;
        end
    end

    // axis length root, one bit a stage
    t_lenp             l_in;
    t_lenp             l_out;
    logic [ROOT_W-1:0] l_root;

    always_comb begin
        l_in.mag  = r3_mag;
        l_in.neg  = r3_neg;
        l_in.c    = r3_c;
        l_in.dneg = r3_dneg;
        l_in.sarg = ONE_SQ - r3_cc;
    end

    vam_isqrt #(
        .W  (LEN2_W),
        .PW ($bits(t_lenp))
    ) u_len_root (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_arg  (r3_len2),
        .i_pass (l_in),
        .o_root (l_root),
        .o_pass (l_out)
    );

    // unit axis by rounded divide, sine root alongside with equal depth
    logic [QW-1:0] q_quo [AX_N];
    logic          q_neg [AX_N];

    for (genvar j = 0; j < AX_N; j++) begin : g_axis
        logic [NUMW-1:0] num;

        assign num = (NUMW'(l_out.mag[j]) << F) + NUMW'(l_root >> 1);

        vam_div #(
            .DW (ROOT_W),
            .QW (QW),
            .PW (1)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (num[NUMW-1:QW]),
            .i_lo   (num[QW-1:0]),
            .i_den  (l_root),
            .i_pass (l_out.neg[j]),
            .o_quo  (q_quo[j]),
            .o_pass (q_neg[j])
        );
    end

    t_sinp         s_in;
    t_sinp         s_out;
    logic [QW-1:0] s_root;

    always_comb begin
        s_in.c    = l_out.c;
        s_in.zero = (l_root == '0);
        s_in.dneg = l_out.dneg;
    end

    vam_isqrt #(
        .W  (SQW),
        .PW ($bits(t_sinp))
    ) u_sin_root (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_arg  (l_out.sarg),
        .i_pass (s_in),
        .o_root (s_root),
        .o_pass (s_out)
    );

    // product stage 1: outer products of the axis and sine times axis
    logic signed [KW-1:0]  p_k [AX_N];
    logic signed [KW-1:0]  p_s;
    logic signed [PKW-1:0] n4_kk [KK_N];
    logic signed [PKW-1:0] n4_sk [AX_N];
    logic signed [PKW-1:0] r4_kk [KK_N];
    logic signed [PKW-1:0] r4_sk [AX_N];
    logic signed [KW:0]    r4_t;
    logic signed [KW-1:0]  r4_c;
    logic                  r4_zero;
    logic                  r4_dneg;

    always_comb begin
        for (int j = 0; j < AX_N; j++) begin
            p_k[j] = q_neg[j] ? -$signed({1'b0, q_quo[j]}) : $signed({1'b0, q_quo[j]});
        end
        p_s = $signed({1'b0, s_root});
        n4_kk[KK_XX] = p_k[AX_X] * p_k[AX_X];
        n4_kk[KK_YY] = p_k[AX_Y] * p_k[AX_Y];
        n4_kk[KK_ZZ] = p_k[AX_Z] * p_k[AX_Z];
        n4_kk[KK_XY] = p_k[AX_X] * p_k[AX_Y];
        n4_kk[KK_XZ] = p_k[AX_X] * p_k[AX_Z];
        n4_kk[KK_YZ] = p_k[AX_Y] * p_k[AX_Z];
        for (int j = 0; j < AX_N; j++) begin
            n4_sk[j] = p_s * p_k[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_kk   <= n4_kk;
            r4_sk   <= n4_sk;
            r4_t    <= ONE_T - (KW+1)'(s_out.c);
            r4_c    <= s_out.c;
            r4_zero <= s_out.zero;
            r4_dneg <= s_out.dneg;
        end
    end

    // product stage 2: round both product sets
    logic signed [XW-1:0] n5_x_kk [KK_N];
    logic signed [XW-1:0] n5_x_sk [AX_N];
    logic signed [KW-1:0] r5_rkk  [KK_N];
    logic signed [KW-1:0] r5_rsk  [AX_N];
    logic signed [KW:0]   r5_t;
    logic signed [KW-1:0] r5_c;
    logic                 r5_zero;
    logic                 r5_dneg;

    always_comb begin
        for (int i = 0; i < KK_N; i++) begin
            n5_x_kk[i] = rshr(XW'(r4_kk[i]));
        end
        for (int j = 0; j < AX_N; j++) begin
            n5_x_sk[j] = rshr(XW'(r4_sk[j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < KK_N; i++) begin
                r5_rkk[i] <= n5_x_kk[i][KW-1:0];
            end
            for (int j = 0; j < AX_N; j++) begin
                r5_rsk[j] <= n5_x_sk[j][KW-1:0];
            end
            r5_t    <= r4_t;
            r5_c    <= r4_c;
            r5_zero <= r4_zero;
            r5_dneg <= r4_dneg;
        end
    end

    // product stage 3: scale outer products by one minus cosine
    logic signed [TW-1:0] n6_tk [KK_N];
    logic signed [TW-1:0] r6_tk [KK_N];
    logic signed [KW-1:0] r6_rsk [AX_N];
    logic signed [KW-1:0] r6_c;
    logic                 r6_zero;
    logic                 r6_dneg;

    always_comb begin
        for (int i = 0; i < KK_N; i++) begin
            n6_tk[i] = r5_t * r5_rkk[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_tk   <= n6_tk;
            r6_rsk  <= r5_rsk;
            r6_c    <= r5_c;
            r6_zero <= r5_zero;
            r6_dneg <= r5_dneg;
        end
    end

    // output stage: assemble, saturate, identity on a vanishing axis
    logic signed [XW-1:0] n7_x_tk [KK_N];
    logic signed [EW-1:0] n7_tk   [KK_N];
    logic signed [EW-1:0] n7_sk   [AX_N];
    logic signed [EW-1:0] n7_c;
    t_out_item            n7_out;
    t_out_item            r_out;

    always_comb begin
        for (int i = 0; i < KK_N; i++) begin
            n7_x_tk[i] = rshr(XW'(r6_tk[i]));
            n7_tk[i]   = n7_x_tk[i][EW-1:0];
        end
        for (int j = 0; j < AX_N; j++) begin
            n7_sk[j] = EW'(r6_rsk[j]);
        end
        n7_c = EW'(r6_c);
        if (r6_zero) begin
            n7_out.r00 = ONE_E[FIELD_W-1:0];
            n7_out.r01 = '0;
            n7_out.r02 = '0;
            n7_out.r10 = '0;
            n7_out.r11 = ONE_E[FIELD_W-1:0];
            n7_out.r12 = '0;
            n7_out.r20 = '0;
            n7_out.r21 = '0;
            n7_out.r22 = ONE_E[FIELD_W-1:0];
        end else begin
            n7_out.r00 = sat16(n7_c + n7_tk[KK_XX]);
            n7_out.r01 = sat16(n7_tk[KK_XY] - n7_sk[AX_Z]);
            n7_out.r02 = sat16(n7_tk[KK_XZ] + n7_sk[AX_Y]);
            n7_out.r10 = sat16(n7_tk[KK_XY] + n7_sk[AX_Z]);
            n7_out.r11 = sat16(n7_c + n7_tk[KK_YY]);
            n7_out.r12 = sat16(n7_tk[KK_YZ] - n7_sk[AX_X]);
            n7_out.r20 = sat16(n7_tk[KK_XZ] - n7_sk[AX_Y]);
            n7_out.r21 = sat16(n7_tk[KK_YZ] + n7_sk[AX_X]);
            n7_out.r22 = sat16(n7_c + n7_tk[KK_ZZ]);
        end
        // opposite vectors: axis undefined
        n7_out.antiparallel_flag = r6_zero && r6_dneg;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n7_out;
        end
    end

    assign o_item = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/vam_chk.sv
// vam_chk: port-level checks on the vector align rotation matrix core
// depends on vam_pkg; bound to the core at the end of this file
`default_nettype none

module vam_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input vam_pkg::t_out_item  o_item
);

    import vam_pkg::*;

    // input side only stalls behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("held result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // flagged items carry the identity pattern: zero off the diagonal, equal entries on it
    a_flag_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.antiparallel_flag) |->
        (o_item.r01 == '0 && o_item.r02 == '0 && o_item.r10 == '0 &&
         o_item.r12 == '0 && o_item.r20 == '0 && o_item.r21 == '0 &&
         o_item.r00 == o_item.r11 && o_item.r11 == o_item.r22))
        else $error("flagged item is not the identity");

endmodule

bind vector_align_rotation_matrix_core vam_chk u_vam_chk (.*);

`default_nettype wire

FILE: tb/tb_vector_align_rotation_matrix_core.sv
// testbench for vector_align_rotation_matrix_core: directed table then random vector pairs
// depends on vam_pkg and the core; self-checking against an in-bench matrix predictor
`default_nettype none

module tb_vector_align_rotation_matrix_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vam_pkg::*;

    localparam int FB       = 14;
    localparam longint ONE  = 64'sd1 <<< FB;
    localparam int LATENCY  = 40 + FB;
    localparam int N_RANDOM = 1430;
    localparam longint CYCLE_LIMIT = 400000;

    // kind of expectation typed into a directed row
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_IDENTITY,
        ROW_IDENTITY_FLAG
    } t_row_kind;

    typedef struct {
        longint    sx, sy, sz, mx, my, mz;
        t_row_kind kind;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_in_item   i_item = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_out_item  o_item;

    t_out_item  matrix_queue[$];
    int         mismatch_count = 0;
    int         matrices_seen = 0;
    int         flags_seen = 0;
    int         identities_seen = 0;
    longint     cycle_count = 0;
    bit         quiet_sink = 1'b0;

    vector_align_rotation_matrix_core #(.FRAC_BITS(FB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always #6 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic longint sext16(input logic [15:0] v);
        return longint'($signed(v));
    endfunction

    // integer square root, floor
    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // scale down by the fraction bits, halves away from zero
    function automatic longint round_frac(input longint x);
        longint unsigned m;
        m = ((x < 0) ? -x : x);
        m = (m + (64'd1 << (FB - 1))) >> FB;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint round_div(input longint num, input longint unsigned den);
        longint unsigned m;
        m = (num < 0) ? -num : num;
        m = (m + den / 2) / den;
        return (num < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [15:0] clip_one(input longint x);
        if (x > ONE) return 16'(ONE);
        if (x < -ONE) return 16'(-ONE);
        return 16'(x);
    endfunction

    function automatic t_out_item identity_matrix(input logic flag);
        t_out_item r;
        r = '0;
        r.r00 = 16'(ONE);
        r.r11 = 16'(ONE);
        r.r22 = 16'(ONE);
        r.antiparallel_flag = flag;
        return r;
    endfunction

    // rotation matrix turning the material direction onto the spatial one
    function automatic t_out_item rotation_from_pair(input t_in_item it);
        longint sx, sy, sz, mx, my, mz, ax, ay, az, dot;
        longint kx, ky, kz, c, s, t;
        longint txx, tyy, tzz, txy, txz, tyz, sxk, syk, szk;
        longint unsigned len2, n;
        t_out_item r;
        sx = sext16(it.spatial_x);  sy = sext16(it.spatial_y);  sz = sext16(it.spatial_z);
        mx = sext16(it.material_x); my = sext16(it.material_y); mz = sext16(it.material_z);
        ax = my * sz - mz * sy;
        ay = mz * sx - mx * sz;
        az = mx * sy - my * sx;
        dot = mx * sx + my * sy + mz * sz;
        len2 = longint'(ax * ax) + longint'(ay * ay) + longint'(az * az);
        n = int_root(len2);
        if (n == 0) return identity_matrix(dot < 0);
        kx = round_div(ax * ONE, n);
        ky = round_div(ay * ONE, n);
        kz = round_div(az * ONE, n);
        c = round_frac(dot);
        if (c > ONE) c = ONE;
        if (c < -ONE) c = -ONE;
        s = longint'(int_root(ONE * ONE - c * c));
        t = ONE - c;
        txx = round_frac(t * round_frac(kx * kx));
        tyy = round_frac(t * round_frac(ky * ky));
        tzz = round_frac(t * round_frac(kz * kz));
        txy = round_frac(t * round_frac(kx * ky));
        txz = round_frac(t * round_frac(kx * kz));
        tyz = round_frac(t * round_frac(ky * kz));
        sxk = round_frac(s * kx);
        syk = round_frac(s * ky);
        szk = round_frac(s * kz);
        r.r00 = clip_one(c + txx);
        r.r01 = clip_one(txy - szk);
        r.r02 = clip_one(txz + syk);
        r.r10 = clip_one(txy + szk);
        r.r11 = clip_one(c + tyy);
        r.r12 = clip_one(tyz - sxk);
        r.r20 = clip_one(txz - syk);
        r.r21 = clip_one(tyz + sxk);
        r.r22 = clip_one(c + tzz);
        r.antiparallel_flag = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    endtask

    // result sink: stalls about 14 in 100 except during a quiet stretch
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (matrix_queue.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = matrix_queue.pop_front();
                matrices_seen++;
                if (o_item.antiparallel_flag) flags_seen++;
                if (o_item == identity_matrix(o_item.antiparallel_flag)) identities_seen++;
                if (o_item.r00 != want.r00) report_mismatch("r00", o_item.r00, want.r00);
                if (o_item.r01 != want.r01) report_mismatch("r01", o_item.r01, want.r01);
                if (o_item.r02 != want.r02) report_mismatch("r02", o_item.r02, want.r02);
                if (o_item.r10 != want.r10) report_mismatch("r10", o_item.r10, want.r10);
                if (o_item.r11 != want.r11) report_mismatch("r11", o_item.r11, want.r11);
                if (o_item.r12 != want.r12) report_mismatch("r12", o_item.r12, want.r12);
                if (o_item.r20 != want.r20) report_mismatch("r20", o_item.r20, want.r20);
                if (o_item.r21 != want.r21) report_mismatch("r21", o_item.r21, want.r21);
                if (o_item.r22 != want.r22) report_mismatch("r22", o_item.r22, want.r22);
                if (o_item.antiparallel_flag != want.antiparallel_flag)
                    report_mismatch("antiparallel_flag", o_item.antiparallel_flag,
                                    want.antiparallel_flag);
            end
        end
        i_stall <= quiet_sink ? 1'b0 : ($urandom_range(99) < 14);
    end

    // random unit-ish component pair helpers
    function automatic logic [15:0] rand_comp();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return 16'($signed($urandom_range(32768)) - 16384);
        if (pick < 90) return 16'($urandom);
        return (pick < 95) ? 16'(ONE) : 16'(-ONE);
    endfunction

    // random vector pair: independent components, some pairs made parallel, antiparallel or zero
    task automatic rand_pair(output t_in_item it);
        int mode;
        mode = $urandom_range(99);
        it.spatial_x = rand_comp(); it.spatial_y = rand_comp(); it.spatial_z = rand_comp();
        it.material_x = rand_comp(); it.material_y = rand_comp(); it.material_z = rand_comp();
        if (mode < 10) begin
            // parallel pair, exact copy
            it.material_x = it.spatial_x; it.material_y = it.spatial_y;
            it.material_z = it.spatial_z;
        end else if (mode < 20) begin
            // antiparallel pair
            it.material_x = -it.spatial_x; it.material_y = -it.spatial_y;
            it.material_z = -it.spatial_z;
        end else if (mode < 24) begin
            it.material_x = '0; it.material_y = '0; it.material_z = '0;
        end
    endtask

    task automatic send_item(input t_in_item it, input t_out_item want);
        // idle gap before the item, skipped during the quiet stretch
        while (!quiet_sink && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        matrix_queue.insert(matrix_queue.size(), want);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    initial begin
        t_stim_row rows[$];
        t_in_item  it;
        t_out_item want;
        int        wait_cycles;

        // directed: axes, extremes, parallel, antiparallel, zero and out-of-range
        rows = '{
            '{0, 0, 0, 0, 0, 0, ROW_IDENTITY},
            '{16384, 0, 0, 16384, 0, 0, ROW_IDENTITY},
            '{16384, 0, 0, -16384, 0, 0, ROW_IDENTITY_FLAG},
            '{0, -16384, 0, 0, 16384, 0, ROW_IDENTITY_FLAG},
            '{0, 0, 16384, 0, 0, -16384, ROW_IDENTITY_FLAG},
            '{0, 0, -16384, 0, 0, -16384, ROW_IDENTITY},
            '{16384, 0, 0, 0, 0, 0, ROW_IDENTITY},
            '{0, 16384, 0, 16384, 0, 0, ROW_PREDICT},
            '{0, 0, 16384, 0, 16384, 0, ROW_PREDICT},
            '{16384, 0, 0, 0, 0, 16384, ROW_PREDICT},
            '{-16384, 0, 0, 0, -16384, 0, ROW_PREDICT},
            '{11585, 11585, 0, 16384, 0, 0, ROW_PREDICT},
            '{9459, 9459, 9459, 0, 0, 16384, ROW_PREDICT},
            '{32767, -32768, 32767, -32768, 32767, 1, ROW_PREDICT},
            '{-32768, -32768, -32768, 32767, 32767, 32767, ROW_PREDICT},
            '{-32768, -32768, -32768, -32768, -32768, -32768, ROW_IDENTITY},
            '{1, 0, 0, 0, 1, 0, ROW_PREDICT},
            '{16384, 1, 0, 16384, 0, 0, ROW_PREDICT},
            '{-1, -1, -1, 1, 1, 1, ROW_IDENTITY_FLAG},
            '{16384, 16384, 16384, -16384, 16384, -16384, ROW_PREDICT}
        };

        i_valid <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            it.spatial_x  = 16'(rows[k].sx); it.spatial_y  = 16'(rows[k].sy);
            it.spatial_z  = 16'(rows[k].sz); it.material_x = 16'(rows[k].mx);
            it.material_y = 16'(rows[k].my); it.material_z = 16'(rows[k].mz);
            case (rows[k].kind)
                ROW_IDENTITY:      want = identity_matrix(1'b0);
                ROW_IDENTITY_FLAG: want = identity_matrix(1'b1);
                default:           want = rotation_from_pair(it);
            endcase
            send_item(it, want);
        end

        // random part, with a stretch of full-rate flow on both sides in the middle
        for (int k = 0; k < N_RANDOM; k++) begin
            quiet_sink = (k >= 500 && k < 700);
            rand_pair(it);
            send_item(it, rotation_from_pair(it));
        end
        quiet_sink = 1'b0;
        i_valid <= 1'b0;

        // drain: results outstanding, then a latency margin
        wait_cycles = 0;
        while (matrix_queue.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("checked %0d matrices, %0d identity, %0d antiparallel",
                 matrices_seen, identities_seen, flags_seen);
        if (mismatch_count == 0 && matrix_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     matrix_queue.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: vector_align_rotation_matrix_core.f
rtl/core/vam_pkg.sv
rtl/core/vam_isqrt.sv
rtl/core/vam_div.sv
rtl/core/vector_align_rotation_matrix_core.sv
rtl/core/vam_chk.sv
tb/tb_vector_align_rotation_matrix_core.sv
